// File: rtl/core/pbs_pkg.sv
package pbs_pkg;

    typedef enum logic [15:0] {
        PH_IDLE      = 16'h0001,
        PH_LATCH_LO  = 16'h0002,
        PH_CLK_INIT  = 16'h0004,
        PH_DATA      = 16'h0008,
        PH_CLK_LO    = 16'h0010,
        PH_CLK_HI    = 16'h0020,
        PH_TAIL_DATA = 16'h0040,
        PH_TAIL_CLK  = 16'h0080,
        PH_POST      = 16'h0100,
        PH_LATCH_HI  = 16'h0200,
        PH_LATCH_END = 16'h0400,
        PH_SETTLE    = 16'h0800,
        PH_WAIT1     = 16'h1000,
        PH_STROBE_LO = 16'h2000,
        PH_STROBE_HI = 16'h4000,
        PH_WAIT2     = 16'h8000
    } phase_t;

    typedef struct packed {
        logic strobe;
        logic latch;
        logic data;
        logic clk;
    } pins_t;

    typedef struct packed {
        logic [15:0] clock_phase_ticks;
        logic [15:0] latch_phase_ticks;
        logic [31:0] busy_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       shift_clock;
        logic       shift_data;
        logic       latch_level;
        logic       strobe_level;
        logic       ready_res;
        logic       byte_done;
        logic [1:0] timeout_flags;
    } result_t;

    localparam logic [1:0] CFG_CLOCK_PHASE  = 2'd0;
    localparam logic [1:0] CFG_LATCH_PHASE  = 2'd1;
    localparam logic [1:0] CFG_BUSY_TIMEOUT = 2'd2;

    localparam logic [15:0] CLOCK_PHASE_RST  = 16'd5;
    localparam logic [15:0] LATCH_PHASE_RST  = 16'd5;
    localparam logic [31:0] BUSY_TIMEOUT_RST = 32'd1000000;

    localparam int SETTLE_TICKS = 8;
    localparam int STROBE_TICKS = 2;
    localparam logic [3:0] LEAD_ZERO_BITS = 4'd2;
    localparam logic [3:0] BIT_COUNT      = 4'd10;
    localparam logic [3:0] MSB_INDEX      = 4'd9;

endpackage

// File: rtl/core/pbs_cfg.sv
module pbs_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output pbs_pkg::cfg_t      cfg
);

    pbs_pkg::cfg_t cfg_reg;
    pbs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                pbs_pkg::CFG_CLOCK_PHASE:  cfg_next.clock_phase_ticks  = wr_data[15:0];
                pbs_pkg::CFG_LATCH_PHASE:  cfg_next.latch_phase_ticks  = wr_data[15:0];
                pbs_pkg::CFG_BUSY_TIMEOUT: cfg_next.busy_timeout_ticks = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_phase_ticks  <= pbs_pkg::CLOCK_PHASE_RST;
            cfg_reg.latch_phase_ticks  <= pbs_pkg::LATCH_PHASE_RST;
            cfg_reg.busy_timeout_ticks <= pbs_pkg::BUSY_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/pbs_seq.sv
module pbs_seq #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              start_req,
    input  logic [7:0]        data_byte,
    input  logic              busy_level,
    input  pbs_pkg::cfg_t     cfg,
    output pbs_pkg::result_t  res
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    typedef struct packed {
        pbs_pkg::phase_t phase;
        logic [3:0]      bit_idx;
        pbs_pkg::pins_t  pins;
        logic            done;
    } adv_t;

    pbs_pkg::phase_t            phase_reg,   phase_next;
    logic [COUNTER_WIDTH-1:0]   wait_cnt_reg, wait_cnt_next;
    logic [3:0]                 bit_idx_reg, bit_idx_next;
    logic [7:0]                 byte_reg,    byte_next;
    pbs_pkg::pins_t             pins_reg,    pins_next;
    logic [1:0]                 tflag_reg,   tflag_next;
    logic                       done;
    logic                       rdy;
    adv_t                       adv_a;
    adv_t                       adv_b;

    function automatic logic [COUNTER_WIDTH-1:0] hold_len(input logic [15:0] v);
        logic [15:0] h;
        h = (v == 16'd0) ? 16'd1 : v;
        return COUNTER_WIDTH'(h);
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] enter_count(input pbs_pkg::phase_t p,
                                                             input pbs_pkg::cfg_t c);
        logic [COUNTER_WIDTH-1:0] n;
        unique case (p)
            pbs_pkg::PH_LATCH_LO, pbs_pkg::PH_POST,
            pbs_pkg::PH_LATCH_HI, pbs_pkg::PH_LATCH_END:
                n = hold_len(c.latch_phase_ticks);
            pbs_pkg::PH_CLK_INIT, pbs_pkg::PH_DATA, pbs_pkg::PH_CLK_LO,
            pbs_pkg::PH_CLK_HI, pbs_pkg::PH_TAIL_DATA, pbs_pkg::PH_TAIL_CLK:
                n = hold_len(c.clock_phase_ticks);
            pbs_pkg::PH_SETTLE:
                n = COUNTER_WIDTH'(pbs_pkg::SETTLE_TICKS);
            pbs_pkg::PH_STROBE_LO, pbs_pkg::PH_STROBE_HI:
                n = COUNTER_WIDTH'(pbs_pkg::STROBE_TICKS);
            default:
                n = '0;
        endcase
        return n;
    endfunction

    // one sequence step: leave phase p, enter its successor
    function automatic adv_t advance(input pbs_pkg::phase_t p, input logic [3:0] bi,
                                     input pbs_pkg::pins_t pins, input logic [7:0] byt);
        adv_t       a;
        logic [3:0] sh;
        a.bit_idx = bi;
        a.pins    = pins;
        a.done    = (p == pbs_pkg::PH_WAIT2);
        if (p == pbs_pkg::PH_CLK_INIT)
        begin
            a.bit_idx = 4'd0;
        end
        else if (p == pbs_pkg::PH_CLK_HI)
        begin
            a.bit_idx = bi + 4'd1;
        end
        unique case (p)
            pbs_pkg::PH_LATCH_LO:  a.phase = pbs_pkg::PH_CLK_INIT;
            pbs_pkg::PH_CLK_INIT:  a.phase = pbs_pkg::PH_DATA;
            pbs_pkg::PH_DATA:      a.phase = pbs_pkg::PH_CLK_LO;
            pbs_pkg::PH_CLK_LO:    a.phase = pbs_pkg::PH_CLK_HI;
            pbs_pkg::PH_CLK_HI:    a.phase = (a.bit_idx < pbs_pkg::BIT_COUNT) ?
                                             pbs_pkg::PH_DATA : pbs_pkg::PH_TAIL_DATA;
            pbs_pkg::PH_TAIL_DATA: a.phase = pbs_pkg::PH_TAIL_CLK;
            pbs_pkg::PH_TAIL_CLK:  a.phase = pbs_pkg::PH_POST;
            pbs_pkg::PH_POST:      a.phase = pbs_pkg::PH_LATCH_HI;
            pbs_pkg::PH_LATCH_HI:  a.phase = pbs_pkg::PH_LATCH_END;
            pbs_pkg::PH_LATCH_END: a.phase = pbs_pkg::PH_SETTLE;
            pbs_pkg::PH_SETTLE:    a.phase = pbs_pkg::PH_WAIT1;
            pbs_pkg::PH_WAIT1:     a.phase = pbs_pkg::PH_STROBE_LO;
            pbs_pkg::PH_STROBE_LO: a.phase = pbs_pkg::PH_STROBE_HI;
            pbs_pkg::PH_STROBE_HI: a.phase = pbs_pkg::PH_WAIT2;
            default:               a.phase = pbs_pkg::PH_IDLE;
        endcase
        sh = pbs_pkg::MSB_INDEX - a.bit_idx;
        unique case (a.phase)
            pbs_pkg::PH_CLK_INIT, pbs_pkg::PH_CLK_LO, pbs_pkg::PH_TAIL_CLK:
                a.pins.clk = 1'b0;
            pbs_pkg::PH_CLK_HI:
                a.pins.clk = 1'b1;
            pbs_pkg::PH_DATA:
                a.pins.data = (a.bit_idx < pbs_pkg::LEAD_ZERO_BITS) ? 1'b0 : byt[sh[2:0]];
            pbs_pkg::PH_TAIL_DATA:
                a.pins.data = 1'b0;
            pbs_pkg::PH_LATCH_HI:
                a.pins.latch = 1'b1;
            pbs_pkg::PH_LATCH_LO, pbs_pkg::PH_LATCH_END:
                a.pins.latch = 1'b0;
            pbs_pkg::PH_STROBE_LO:
                a.pins.strobe = 1'b0;
            pbs_pkg::PH_STROBE_HI:
                a.pins.strobe = 1'b1;
            default:
                a.pins = pins;
        endcase
        return a;
    endfunction

    always_comb
    begin
        phase_next    = phase_reg;
        wait_cnt_next = wait_cnt_reg;
        bit_idx_next  = bit_idx_reg;
        byte_next     = byte_reg;
        pins_next     = pins_reg;
        tflag_next    = tflag_reg;
        done          = 1'b0;
        rdy           = (phase_reg == pbs_pkg::PH_IDLE);
        adv_a         = advance(phase_reg, bit_idx_reg, pins_reg, byte_reg);

        if (rdy)
        begin
            if (start_req)
            begin
                byte_next       = data_byte;
                bit_idx_next    = 4'd0;
                tflag_next      = 2'b00;
                phase_next      = pbs_pkg::PH_LATCH_LO;
                pins_next.latch = 1'b0;
                wait_cnt_next   = enter_count(pbs_pkg::PH_LATCH_LO, cfg);
            end
        end
        else if (phase_reg != pbs_pkg::PH_WAIT1 && phase_reg != pbs_pkg::PH_WAIT2)
        begin
            if (wait_cnt_reg <= CNT_ONE)
            begin
                phase_next    = adv_a.phase;
                bit_idx_next  = adv_a.bit_idx;
                pins_next     = adv_a.pins;
                wait_cnt_next = enter_count(adv_a.phase, cfg);
            end
            else
            begin
                wait_cnt_next = wait_cnt_reg - CNT_ONE;
            end
        end

        // busy wait, checked on the tick it is entered too
        adv_b = advance(phase_next, bit_idx_next, pins_next, byte_next);
        if (phase_next == pbs_pkg::PH_WAIT1 || phase_next == pbs_pkg::PH_WAIT2)
        begin
            if (!busy_level || (32'(wait_cnt_next) > cfg.busy_timeout_ticks))
            begin
                if (busy_level)
                begin
                    tflag_next = tflag_next |
                                 ((phase_next == pbs_pkg::PH_WAIT1) ? 2'b01 : 2'b10);
                end
                phase_next    = adv_b.phase;
                bit_idx_next  = adv_b.bit_idx;
                pins_next     = adv_b.pins;
                done          = adv_b.done;
                wait_cnt_next = enter_count(adv_b.phase, cfg);
            end
            else if (wait_cnt_next != CNT_MAX)
            begin
                wait_cnt_next = wait_cnt_next + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pbs_pkg::PH_IDLE;
            wait_cnt_reg <= '0;
            bit_idx_reg  <= 4'd0;
            byte_reg     <= 8'd0;
            pins_reg     <= '{strobe: 1'b1, latch: 1'b0, data: 1'b0, clk: 1'b0};
            tflag_reg    <= 2'b00;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            wait_cnt_reg <= wait_cnt_next;
            bit_idx_reg  <= bit_idx_next;
            byte_reg     <= byte_next;
            pins_reg     <= pins_next;
            tflag_reg    <= tflag_next;
        end
    end

    always_comb
    begin
        res.shift_clock   = pins_next.clk;
        res.shift_data    = pins_next.data;
        res.latch_level   = pins_next.latch;
        res.strobe_level  = pins_next.strobe;
        res.ready_res     = rdy;
        res.byte_done     = done;
        res.timeout_flags = tflag_next;
    end

    a_start_latch_low: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (phase_reg == pbs_pkg::PH_IDLE) && start_req
        |=> (phase_reg == pbs_pkg::PH_LATCH_LO) && !pins_reg.latch && (tflag_reg == 2'b00))
        else $error("start did not enter latch-low phase");

    a_wait2_release: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (phase_reg == pbs_pkg::PH_WAIT2) && !busy_level
        |=> (phase_reg == pbs_pkg::PH_IDLE) && $past(res.byte_done))
        else $error("second busy wait did not finish the byte");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= pbs_pkg::BIT_COUNT)
        else $error("bit index out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(wait_cnt_reg) && $stable(pins_reg))
        else $error("sequencer moved without a tick");

endmodule

// File: rtl/core/parallel_printer_byte_sender_top.sv
// Parallel printer byte sender.
// Each input item is one time tick: start_req with data_byte requests a
// transfer (taken only on a tick whose result shows ready_res), busy_level
// is the printer busy line sampled on that tick.
// Each accepted item produces exactly one result item holding the shift
// register pin levels (clock, data, latch), the strobe level, ready_res,
// a byte_done pulse and the timeout flags of the current or last byte.
// The result is registered, valid in the cycle after input accept; one item
// per cycle is sustained while out_ready is high, since each tick update is
// one pass of the phase sequencer between its state and result registers.
// When the result side stalls, the result register holds and in_ready
// drops; the sequencer does not advance until the next item is accepted.
// Configuration writes (cfg_index 0 clock phase, 1 latch phase, 2 busy
// timeout) are always taken; unknown indexes are ignored.
// Reset: phase idle, strobe high, other pins low, flags clear, registers
// at their defaults, no result pending.
module parallel_printer_byte_sender_top #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [7:0]  data_byte,
    input  logic        busy_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        shift_clock,
    output logic        shift_data,
    output logic        latch_level,
    output logic        strobe_level,
    output logic        ready_res,
    output logic        byte_done,
    output logic [1:0]  timeout_flags,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pbs_pkg::cfg_t    cfg;
    pbs_pkg::result_t res_comb;
    pbs_pkg::result_t res_reg;
    logic             out_valid_reg, out_valid_next;
    logic             in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    pbs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pbs_seq #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_accept),
        .start_req  (start_req),
        .data_byte  (data_byte),
        .busy_level (busy_level),
        .cfg        (cfg),
        .res        (res_comb)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shift_clock   = res_reg.shift_clock;
    assign shift_data    = res_reg.shift_data;
    assign latch_level   = res_reg.latch_level;
    assign strobe_level  = res_reg.strobe_level;
    assign ready_res     = res_reg.ready_res;
    assign byte_done     = res_reg.byte_done;
    assign timeout_flags = res_reg.timeout_flags;

endmodule
